// File: rtl/cbs_pkg.sv
// -----------------------------------------------------------------------------
// cbs_pkg
// Shared types and constants for the cell balance selector.
// -----------------------------------------------------------------------------
package cbs_pkg;

   // cells in one run
   localparam int CELLS     = 16;
   localparam int IDX_W     = $clog2(CELLS);
   localparam int CNT_W     = $clog2(CELLS + 1);

   // field widths
   localparam int VOLT_W    = 16;
   localparam int LIMIT_W   = VOLT_W + 1;
   localparam int OUT_IDX_W = 6;
   localparam int OUT_CNT_W = 7;

   localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(CELLS - 1);
   localparam logic [VOLT_W-1:0] VOLT_ONES = '1;

   // run descriptor handed from front to back
   typedef struct packed {
      logic [LIMIT_W-1:0] limit;
      logic               skip_odd;
   } desc_type;

   // voltage store write beat
   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  addr;
      logic [VOLT_W-1:0] data;
   } vwr_type;

   // sorted entry: cell index and below-limit flag
   typedef struct packed {
      logic [IDX_W-1:0] idx;
      logic             below;
   } ord_type;

   // back-end sequencer
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_HOLD,
      ST_CMP,
      ST_WRITE,
      ST_PRIME,
      ST_EMIT
   } back_state_type;

endpackage

// File: rtl/cell_balance_selector_top.sv
// -----------------------------------------------------------------------------
// cell_balance_selector_top
// Cell balance selector: loads one run of cell voltages, ranks them and
// reports per sorted position whether the cell is balanced this run.
// -----------------------------------------------------------------------------
// Loading: one voltage per cycle while busy is low; the last cell queues the run.
// Ranking reads the store once per compare: each cell is fetched, compared with
// every cell and its rank written; result beats then follow one a cycle.
// Loading overlaps emission only. Synchronous active-high reset clears control
// state, threshold to zero and rests odd cells first; results cannot be
// stalled by the receiver.
// -----------------------------------------------------------------------------
module cell_balance_selector_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [cbs_pkg::VOLT_W-1:0]    req_cell_voltage,
   output logic                          rsp_strobe,
   output logic [cbs_pkg::OUT_IDX_W-1:0] rsp_cell_index,
   output logic                          rsp_skipped,
   output logic [cbs_pkg::OUT_CNT_W-1:0] rsp_unbalanced_count,
   output logic                          rsp_last_of_run,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [cbs_pkg::VOLT_W-1:0]    csr_data
);

   logic              q_full;
   logic              q_push;
   logic              q_pop;
   cbs_pkg::desc_type q_desc;
   cbs_pkg::desc_type q_head;
   cbs_pkg::vwr_type  vwr;

   // load side
   cbs_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cell_voltage (req_cell_voltage),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_desc           (q_desc),
      .vwr              (vwr)
   );

   // pending run
   cbs_run_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (q_desc),
      .pop       (q_pop),
      .full      (q_full),
      .head      (q_head)
   );

   // rank and emit side
   cbs_back u_back (
      .clock                (clock),
      .reset                (reset),
      .vwr                  (vwr),
      .q_full               (q_full),
      .q_head               (q_head),
      .q_pop                (q_pop),
      .rsp_strobe           (rsp_strobe),
      .rsp_cell_index       (rsp_cell_index),
      .rsp_skipped          (rsp_skipped),
      .rsp_unbalanced_count (rsp_unbalanced_count),
      .rsp_last_of_run      (rsp_last_of_run)
   );

endmodule

// File: rtl/cbs_front.sv
// -----------------------------------------------------------------------------
// cbs_front
// Takes cell voltages, writes them to the store, tracks the run minimum and
// hands a run descriptor to the queue after the last cell.
// -----------------------------------------------------------------------------
module cbs_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [cbs_pkg::VOLT_W-1:0]    req_cell_voltage,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [cbs_pkg::VOLT_W-1:0]    csr_data,
   input  logic                          q_full,
   output logic                          q_push,
   output cbs_pkg::desc_type             q_desc,
   output cbs_pkg::vwr_type              vwr
);

   logic [cbs_pkg::IDX_W-1:0]  load_cnt_ff, load_cnt_in;
   logic [cbs_pkg::VOLT_W-1:0] min_ff, min_in;
   logic                       odd_ff, odd_in;
   logic [cbs_pkg::VOLT_W-1:0] thr_ff;
   logic                       accept;
   logic                       last_cell;
   logic [cbs_pkg::VOLT_W-1:0] new_min;

   // a pending run owns the store until the back end has sorted it
   assign busy      = q_full;
   assign csr_ready = 1'b1;
   assign accept    = start & ~q_full;
   assign last_cell = (load_cnt_ff == cbs_pkg::LAST_IDX);
   assign new_min   = (req_cell_voltage < min_ff) ? req_cell_voltage : min_ff;

   // store write beat
   assign vwr.en   = accept;
   assign vwr.addr = load_cnt_ff;
   assign vwr.data = req_cell_voltage;

   // descriptor: limit formed at 17 bits
   assign q_push         = accept & last_cell;
   assign q_desc.limit   = cbs_pkg::LIMIT_W'(new_min) + cbs_pkg::LIMIT_W'(thr_ff);
   assign q_desc.skip_odd = odd_ff;

   // load sequencing
   always_comb begin
      load_cnt_in = load_cnt_ff;
      min_in      = min_ff;
      odd_in      = odd_ff;
      if (accept) begin
         if (last_cell) begin
            load_cnt_in = '0;
            min_in      = cbs_pkg::VOLT_ONES;
            odd_in      = ~odd_ff;
         end else begin
            load_cnt_in = load_cnt_ff + 1'b1;
            min_in      = new_min;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_cnt_ff <= '0;
         min_ff      <= cbs_pkg::VOLT_ONES;
         odd_ff      <= 1'b1;
         thr_ff      <= '0;
      end else begin
         load_cnt_ff <= load_cnt_in;
         min_ff      <= min_in;
         odd_ff      <= odd_in;
         if (csr_valid) begin
            thr_ff <= csr_data;
         end
      end
   end

endmodule

// File: rtl/cbs_run_queue.sv
// -----------------------------------------------------------------------------
// cbs_run_queue
// One-entry queue of run descriptors between front and back.
// -----------------------------------------------------------------------------
module cbs_run_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cbs_pkg::desc_type push_desc,
   input  logic              pop,
   output logic              full,
   output cbs_pkg::desc_type head
);

   logic              valid_ff, valid_in;
   cbs_pkg::desc_type data_ff;

   assign full = valid_ff;
   assign head = data_ff;

   // occupancy
   always_comb begin
      valid_in = valid_ff;
      if (pop) begin
         valid_in = 1'b0;
      end
      if (push) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (push) begin
         data_ff <= push_desc;
      end
   end

endmodule

// File: rtl/cbs_back.sv
// -----------------------------------------------------------------------------
// cbs_back
// Ranks the stored cells by voltage (stable, highest first), builds the sorted
// order in a small memory, then emits one result beat per cell.
// -----------------------------------------------------------------------------
module cbs_back (
   input  logic                              clock,
   input  logic                              reset,
   input  cbs_pkg::vwr_type                  vwr,
   input  logic                              q_full,
   input  cbs_pkg::desc_type                 q_head,
   output logic                              q_pop,
   output logic                              rsp_strobe,
   output logic [cbs_pkg::OUT_IDX_W-1:0]     rsp_cell_index,
   output logic                              rsp_skipped,
   output logic [cbs_pkg::OUT_CNT_W-1:0]     rsp_unbalanced_count,
   output logic                              rsp_last_of_run
);

   // memories
   logic [cbs_pkg::VOLT_W-1:0] volt_mem [cbs_pkg::CELLS];
   cbs_pkg::ord_type           ord_mem  [cbs_pkg::CELLS];
   logic [cbs_pkg::IDX_W-1:0]  vrd_addr;
   logic [cbs_pkg::VOLT_W-1:0] vrd_ff;
   logic                       ord_we;
   logic [cbs_pkg::IDX_W-1:0]  ord_waddr;
   cbs_pkg::ord_type           ord_wdata;
   logic [cbs_pkg::IDX_W-1:0]  ord_raddr;
   cbs_pkg::ord_type           ord_rd_ff;

   // sequencer
   cbs_pkg::back_state_type     state_ff, state_in;
   logic [cbs_pkg::IDX_W-1:0]   i_ff, i_in;
   logic [cbs_pkg::IDX_W-1:0]   j_ff, j_in;
   logic [cbs_pkg::IDX_W-1:0]   k_ff, k_in;
   logic [cbs_pkg::IDX_W-1:0]   rank_ff, rank_in;
   logic [cbs_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [cbs_pkg::VOLT_W-1:0]  vi_ff, vi_in;
   logic                        below_ff, below_in;
   logic [cbs_pkg::LIMIT_W-1:0] limit_ff, limit_in;
   logic                        odd_ff, odd_in;
   logic                        ahead;

   // result registers
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [cbs_pkg::OUT_IDX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic                          rsp_skip_ff, rsp_skip_in;
   logic [cbs_pkg::OUT_CNT_W-1:0] rsp_cnt_ff, rsp_cnt_in;
   logic                          rsp_last_ff, rsp_last_in;

   // voltage store: written by the front, read here
   always_ff @(posedge clock) begin
      if (vwr.en) begin
         volt_mem[vwr.addr] <= vwr.data;
      end
      vrd_ff <= volt_mem[vrd_addr];
   end

   // sorted order store
   always_ff @(posedge clock) begin
      if (ord_we) begin
         ord_mem[ord_waddr] <= ord_wdata;
      end
      ord_rd_ff <= ord_mem[ord_raddr];
   end

   // cell j outranks cell i: higher voltage, or equal and lower index
   assign ahead = (vrd_ff > vi_ff) || ((vrd_ff == vi_ff) && (j_ff < i_ff));

   // next state and outputs
   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      rank_in      = rank_ff;
      cnt_in       = cnt_ff;
      vi_in        = vi_ff;
      below_in     = below_ff;
      limit_in     = limit_ff;
      odd_in       = odd_ff;
      vrd_addr     = i_ff;
      ord_we       = 1'b0;
      ord_waddr    = rank_ff;
      ord_wdata    = '{idx: i_ff, below: below_ff};
      ord_raddr    = k_ff;
      q_pop        = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_idx_in   = rsp_idx_ff;
      rsp_skip_in  = rsp_skip_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         cbs_pkg::ST_IDLE: begin
            if (q_full) begin
               limit_in = q_head.limit;
               odd_in   = q_head.skip_odd;
               i_in     = '0;
               cnt_in   = '0;
               state_in = cbs_pkg::ST_FETCH;
            end
         end
         cbs_pkg::ST_FETCH: begin
            vrd_addr = i_ff;
            state_in = cbs_pkg::ST_HOLD;
         end
         cbs_pkg::ST_HOLD: begin
            vi_in    = vrd_ff;
            below_in = (cbs_pkg::LIMIT_W'(vrd_ff) < limit_ff);
            vrd_addr = '0;
            j_in     = '0;
            rank_in  = '0;
            state_in = cbs_pkg::ST_CMP;
         end
         cbs_pkg::ST_CMP: begin
            rank_in  = rank_ff + cbs_pkg::IDX_W'(ahead);
            vrd_addr = j_ff + 1'b1;
            if (j_ff == cbs_pkg::LAST_IDX) begin
               state_in = cbs_pkg::ST_WRITE;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         cbs_pkg::ST_WRITE: begin
            ord_we = 1'b1;
            cnt_in = below_ff ? cnt_ff : cnt_ff + 1'b1;
            if (i_ff == cbs_pkg::LAST_IDX) begin
               // store no longer needed: release it to the front
               q_pop    = 1'b1;
               state_in = cbs_pkg::ST_PRIME;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = cbs_pkg::ST_FETCH;
            end
         end
         cbs_pkg::ST_PRIME: begin
            ord_raddr = '0;
            k_in      = '0;
            state_in  = cbs_pkg::ST_EMIT;
         end
         cbs_pkg::ST_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_idx_in   = cbs_pkg::OUT_IDX_W'(ord_rd_ff.idx);
            rsp_skip_in  = ord_rd_ff.below | (ord_rd_ff.idx[0] == odd_ff);
            rsp_cnt_in   = cbs_pkg::OUT_CNT_W'(cnt_ff);
            rsp_last_in  = (k_ff == cbs_pkg::LAST_IDX);
            ord_raddr    = k_ff + 1'b1;
            if (k_ff == cbs_pkg::LAST_IDX) begin
               state_in = cbs_pkg::ST_IDLE;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         default: begin
            state_in = cbs_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cbs_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      rank_ff     <= rank_in;
      cnt_ff      <= cnt_in;
      vi_ff       <= vi_in;
      below_ff    <= below_in;
      limit_ff    <= limit_in;
      odd_ff      <= odd_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_skip_ff <= rsp_skip_in;
      rsp_cnt_ff  <= rsp_cnt_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_strobe           = rsp_valid_ff;
   assign rsp_cell_index       = rsp_idx_ff;
   assign rsp_skipped          = rsp_skip_ff;
   assign rsp_unbalanced_count = rsp_cnt_ff;
   assign rsp_last_of_run      = rsp_last_ff;

endmodule

// File: tb/cbs_result_checker.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// cbs_result_checker
// Watches the cell, threshold and result channels of the cell balance
// selector. It keeps its own copy of the run state, ranks each completed run
// and compares every result beat, field by field, with the oldest prediction.
// -----------------------------------------------------------------------------
module cbs_result_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic [cbs_pkg::VOLT_W-1:0]    req_cell_voltage,
   input  logic                          rsp_strobe,
   input  logic [cbs_pkg::OUT_IDX_W-1:0] rsp_cell_index,
   input  logic                          rsp_skipped,
   input  logic [cbs_pkg::OUT_CNT_W-1:0] rsp_unbalanced_count,
   input  logic                          rsp_last_of_run,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [cbs_pkg::VOLT_W-1:0]    csr_data,
   output int                            fail_count,
   output int                            pending_count
);
   import cbs_pkg::*;

   typedef struct packed {
      logic [OUT_IDX_W-1:0] cell_index;
      logic                 skipped;
      logic [OUT_CNT_W-1:0] unbalanced_count;
      logic                 last_of_run;
   } balance_beat_type;

   // shadow run state
   logic [VOLT_W-1:0] cell_volts [CELLS];
   int unsigned       cells_loaded;
   logic [VOLT_W-1:0] pack_min;
   logic              rest_odd;
   logic [VOLT_W-1:0] threshold;
   balance_beat_type  ranked_beats [$];
   int                errors = 0;

   task automatic note_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      errors++;
   endtask

   // load one cell; on the last cell of a run rank it and queue the beats
   task automatic take_cell(input logic [VOLT_W-1:0] volts);
      int               rank [CELLS];
      int               pos;
      int               i;
      int               k;
      logic [IDX_W-1:0] cell_no;
      logic [LIMIT_W-1:0] limit;
      int unsigned      above;
      balance_beat_type beat;
      cell_volts[cells_loaded] = volts;
      if (volts < pack_min) pack_min = volts;
      cells_loaded++;
      if (cells_loaded == CELLS) begin
         // stable insertion sort, highest voltage first
         for (i = 0; i < CELLS; i++) begin
            pos = i;
            while (pos > 0 && cell_volts[rank[pos-1]] < cell_volts[i]) begin
               rank[pos] = rank[pos-1];
               pos--;
            end
            rank[pos] = i;
         end
         // 17-bit limit, cannot wrap
         limit = {1'b0, pack_min} + {1'b0, threshold};
         above = 0;
         for (i = 0; i < CELLS; i++) begin
            if ({1'b0, cell_volts[i]} >= limit) above++;
         end
         for (k = 0; k < CELLS; k++) begin
            cell_no               = IDX_W'(rank[k]);
            beat.cell_index       = OUT_IDX_W'(cell_no);
            beat.skipped          = ({1'b0, cell_volts[cell_no]} < limit) ||
                                    (cell_no[0] == rest_odd);
            beat.unbalanced_count = OUT_CNT_W'(above);
            beat.last_of_run      = (k == CELLS - 1);
            ranked_beats.push_back(beat);
         end
         cells_loaded = 0;
         pack_min     = VOLT_ONES;
         rest_odd     = ~rest_odd;
      end
   endtask

   // sample every channel at the clock edge
   always @(posedge clock) begin : watch
      balance_beat_type want;
      if (reset) begin
         cells_loaded = 0;
         pack_min     = VOLT_ONES;
         rest_odd     = 1'b1;
         threshold    = '0;
         ranked_beats.delete();
      end else begin
         if (csr_valid && csr_ready) threshold = csr_data;
         if (start && !busy) take_cell(req_cell_voltage);
         if (rsp_strobe) begin
            if (ranked_beats.size() == 0) begin
               note_mismatch($sformatf("result beat with no run pending, index %0d",
                                       rsp_cell_index));
            end else begin
               want = ranked_beats.pop_front();
               if (rsp_cell_index !== want.cell_index)
                  note_mismatch($sformatf("cell_index got %0d want %0d",
                                          rsp_cell_index, want.cell_index));
               if (rsp_skipped !== want.skipped)
                  note_mismatch($sformatf("skipped got %b want %b (cell %0d)",
                                          rsp_skipped, want.skipped, want.cell_index));
               if (rsp_unbalanced_count !== want.unbalanced_count)
                  note_mismatch($sformatf("unbalanced_count got %0d want %0d",
                                          rsp_unbalanced_count, want.unbalanced_count));
               if (rsp_last_of_run !== want.last_of_run)
                  note_mismatch($sformatf("last_of_run got %b want %b (cell %0d)",
                                          rsp_last_of_run, want.last_of_run,
                                          want.cell_index));
            end
         end
      end
      fail_count    <= errors;
      pending_count <= ranked_beats.size();
   end

endmodule

// File: tb/cell_balance_selector_top_tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// cell_balance_selector_top_tb
// Drives runs of cell voltages and threshold settings into the cell balance
// selector: one directed run of edge values, then random runs under several
// thresholds and sender idle rates. The checker beside the block predicts and
// compares; this module gives the verdict once every result has drained.
// -----------------------------------------------------------------------------
module cell_balance_selector_top_tb;
   import cbs_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 40;

   // shapes of a random run
   localparam int MODE_SPREAD  = 0;
   localparam int MODE_CLUSTER = 1;
   localparam int MODE_RAILS   = 2;
   localparam int MODE_HIGH    = 3;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [VOLT_W-1:0]     req_cell_voltage;
   logic                  rsp_strobe;
   logic [OUT_IDX_W-1:0]  rsp_cell_index;
   logic                  rsp_skipped;
   logic [OUT_CNT_W-1:0]  rsp_unbalanced_count;
   logic                  rsp_last_of_run;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [VOLT_W-1:0]     csr_data;
   int                    fail_count;
   int                    pending_count;
   int                    cycles = 0;
   int                    idle_pct = 0;

   cell_balance_selector_top u_top (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_cell_voltage     (req_cell_voltage),
      .rsp_strobe           (rsp_strobe),
      .rsp_cell_index       (rsp_cell_index),
      .rsp_skipped          (rsp_skipped),
      .rsp_unbalanced_count (rsp_unbalanced_count),
      .rsp_last_of_run      (rsp_last_of_run),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_data             (csr_data)
   );

   cbs_result_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_cell_voltage     (req_cell_voltage),
      .rsp_strobe           (rsp_strobe),
      .rsp_cell_index       (rsp_cell_index),
      .rsp_skipped          (rsp_skipped),
      .rsp_unbalanced_count (rsp_unbalanced_count),
      .rsp_last_of_run      (rsp_last_of_run),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_data             (csr_data),
      .fail_count           (fail_count),
      .pending_count        (pending_count)
   );

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // present one cell beat; start is left high on return
   task automatic send_cell(input logic [VOLT_W-1:0] volts);
      start            <= 1'b1;
      req_cell_voltage <= volts;
      do @(posedge clock); while (busy);
   endtask

   // random sender gap after a beat
   task automatic idle_gap();
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
   endtask

   // hold off until every ranked beat is out, then let the block settle; it first
   // waits for a clock edge so the checker's count includes the last accepted beat
   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [VOLT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [VOLT_W-1:0] pick_voltage(input int mode, input int base,
                                                      input int span);
      case (mode)
         MODE_SPREAD:  return VOLT_W'($urandom);
         // few distinct levels: ties and values close to the limit
         MODE_CLUSTER: return VOLT_W'(base + $urandom_range(8) * span);
         MODE_RAILS:   return ($urandom_range(1) == 1) ? VOLT_ONES : '0;
         default:      return VOLT_ONES - VOLT_W'($urandom_range(3));
      endcase
   endfunction

   task automatic send_run(input int mode);
      int base;
      int span;
      int c;
      base = $urandom_range(60000);
      span = $urandom_range(1, 300);
      for (c = 0; c < CELLS; c++) begin
         send_cell(pick_voltage(mode, base, span));
         idle_gap();
      end
   endtask

   // stimulus
   initial begin
      logic [VOLT_W-1:0] edge_run [CELLS];
      logic [VOLT_W-1:0] thr;
      int                runs;
      int                ph;
      int                r;
      int                c;
      edge_run = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0001, 16'h8000,
                   16'h7FFF, 16'hAAAA, 16'h5555, 16'hFFFE, 16'h0001, 16'h0064,
                   16'h0064, 16'h8000, 16'h0002, 16'hFFFF};
      reset            <= 1'b1;
      start            <= 1'b0;
      req_cell_voltage <= '0;
      csr_valid        <= 1'b0;
      csr_data         <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed run at the reset threshold: rails, ties, alternating bits
      for (c = 0; c < CELLS; c++) send_cell(edge_run[c]);

      // random phases
      for (ph = 0; ph < 5; ph++) begin
         case (ph)
            0:       begin thr = VOLT_ONES;                   idle_pct = 0;  runs = 2; end
            1:       begin thr = '0;                          idle_pct = 79; runs = 2; end
            2:       begin thr = VOLT_W'($urandom_range(2000)); idle_pct = 12; runs = 2; end
            3:       begin thr = VOLT_W'($urandom);           idle_pct = 0;  runs = 2; end
            default: begin thr = 16'h0001;                    idle_pct = 79; runs = 2; end
         endcase
         wait_drained();
         write_threshold(thr);
         for (r = 0; r < runs; r++) begin
            send_run($urandom_range(MODE_HIGH));
            // sender holds back until the run has fully streamed out
            if (ph == 2 && (r == 0 || $urandom_range(1) == 1)) wait_drained();
         end
      end

      wait_drained();
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
